### design/integer_to_ascii_formatter_macros.svh
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: assertion macros
// Short property wrappers used by the block that checks itself.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ITAF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ITAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/itaf_pkg.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Word types, opcodes, character constants and sequencer states.
// ----------------------------------------------------------------------------
package itaf_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int DIGIT_SLOTS = 16;
    localparam int IDX_W       = $clog2(DIGIT_SLOTS);

    localparam logic [IDX_W-1:0] C_IDX_MAX = IDX_W'(DIGIT_SLOTS - 1);

    // format opcodes
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_HEXL = 3'd2;
    localparam logic [2:0] OP_HEXU = 3'd3;
    localparam logic [2:0] OP_PTR  = 3'd4;

    // characters and digit offsets
    localparam logic [7:0] C_CH_MINUS  = 8'd45;
    localparam logic [7:0] C_CH_ZERO   = 8'd48;
    localparam logic [7:0] C_CH_X      = 8'd120;
    localparam logic [7:0] C_LOWER_OFS = 8'd87;
    localparam logic [7:0] C_UPPER_OFS = 8'd55;

    // ceil(2^35 / 10): floor(v * C_RECIP10 / 2^35) == v / 10 for any 32-bit v
    localparam logic [31:0] C_RECIP10  = 32'hCCCC_CCCD;
    localparam int          RECIP_SH   = 35;
    localparam int          QUOT_W     = 64 - RECIP_SH;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [2:0]             opcode;
    } t_in;

    typedef struct packed {
        logic [7:0]  char_out;
        logic        last;
        logic [31:0] total_chars;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_HEX,
        ST_PRE,
        ST_EMIT
    } t_state;

endpackage

### design/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Decimal digits come from a shared multiply-by-reciprocal divide-by-ten unit
// (a multiply state, then a subtract state per digit), hex digits from a
// nibble shifter (one shift state per digit). Busy after a start through the
// digit, prefix-character and emit states; never busy for unused opcodes.
// Each word is registered before it strobes; the receiver cannot stall.
// Synchronous active-low reset clears the sequencer and the running count.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter
    import itaf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_out o_result
);

    t_state r_state, n_state;

    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [QUOT_W-1:0]      r_quot, n_quot;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [2:0]             r_op, n_op;
    logic                   r_neg, n_neg;
    logic                   r_pre_x, n_pre_x;
    logic [3:0]             r_store [DIGIT_SLOTS];
    logic                   w_store_en;
    logic [3:0]             w_store_d;
    logic [31:0]            r_total, n_total;
    logic                   r_strobe, n_strobe;
    logic [7:0]             r_char, n_char;
    logic                   r_last, n_last;

    logic        w_accept;
    logic        w_neg_in;
    logic [63:0] w_prod;
    logic [31:0] w_rem;
    logic [3:0]  w_digit;
    logic [7:0]  w_digit_ch;
    logic        w_dec_done;
    logic        w_hex_done;
    logic        w_has_pre;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_neg_in = (i_item.opcode == OP_SDEC) && i_item.value[31];

    // shared divide-by-ten unit: multiply, then subtract q*10
    assign w_prod = {32'd0, r_val[31:0]} * {32'd0, C_RECIP10};
    assign w_rem  = r_val[31:0] - {r_quot, 3'b000} - {2'b00, r_quot, 1'b0};

    assign w_dec_done = (r_quot == '0) || (r_idx == C_IDX_MAX);
    assign w_hex_done = (r_val[VALUE_WIDTH-1:4] == '0) || (r_idx == C_IDX_MAX);
    assign w_has_pre  = r_neg || (r_op == OP_PTR);

    assign w_digit    = r_store[r_idx];
    assign w_digit_ch = (w_digit < 4'd10) ? (8'(w_digit) + C_CH_ZERO) :
                        (8'(w_digit) + ((r_op == OP_HEXU) ? C_UPPER_OFS : C_LOWER_OFS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_item.opcode) inside
                        OP_SDEC, OP_UDEC:         n_state = ST_MUL;
                        OP_HEXL, OP_HEXU, OP_PTR: n_state = ST_HEX;
                        default:                  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: n_state = ST_SUB;
            ST_SUB: begin
                if (w_dec_done) begin
                    n_state = w_has_pre ? ST_PRE : ST_EMIT;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_HEX: begin
                if (w_hex_done) begin
                    n_state = w_has_pre ? ST_PRE : ST_EMIT;
                end
            end
            ST_PRE: begin
                if (r_neg || r_pre_x) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_idx == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_val      = r_val;
        n_quot     = r_quot;
        n_idx      = r_idx;
        n_op       = r_op;
        n_neg      = r_neg;
        n_pre_x    = r_pre_x;
        n_total    = r_total;
        n_strobe   = 1'b0;
        n_char     = r_char;
        n_last     = r_last;
        w_store_en = 1'b0;
        w_store_d  = 4'd0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op    = i_item.opcode;
                    n_neg   = w_neg_in;
                    n_pre_x = 1'b0;
                    n_idx   = '0;
                    case (i_item.opcode)
                        OP_SDEC: n_val = {32'd0, w_neg_in ? (32'd0 - i_item.value[31:0])
                                                          : i_item.value[31:0]};
                        OP_UDEC: n_val = {32'd0, i_item.value[31:0]};
                        default: n_val = i_item.value;
                    endcase
                end
            end
            ST_MUL: begin
                n_quot = w_prod[63:RECIP_SH];
            end
            ST_SUB: begin
                w_store_en = 1'b1;
                w_store_d  = w_rem[3:0];
                n_val      = {{(VALUE_WIDTH - QUOT_W){1'b0}}, r_quot};
                if (!w_dec_done) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_HEX: begin
                w_store_en = 1'b1;
                w_store_d  = r_val[3:0];
                n_val      = r_val >> 4;
                if (!w_hex_done) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_PRE: begin
                n_strobe = 1'b1;
                n_last   = 1'b0;
                n_total  = r_total + 32'd1;
                if (r_neg) begin
                    n_char = C_CH_MINUS;
                end else if (r_pre_x) begin
                    n_char = C_CH_X;
                end else begin
                    n_char  = C_CH_ZERO;
                    n_pre_x = 1'b1;
                end
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                n_char   = w_digit_ch;
                n_last   = (r_idx == '0);
                n_total  = r_total + 32'd1;
                if (r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_total  <= 32'd0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_quot  <= n_quot;
        r_idx   <= n_idx;
        r_op    <= n_op;
        r_neg   <= n_neg;
        r_pre_x <= n_pre_x;
        r_char  <= n_char;
        r_last  <= n_last;
        if (w_store_en) begin
            r_store[r_idx] <= w_store_d;
        end
    end

    assign o_strobe             = r_strobe;
    assign o_result.char_out    = r_char;
    assign o_result.last        = r_last;
    assign o_result.total_chars = r_total;

    `ITAF_ASSERT_NOW(a_more_follows, i_clk, i_rst_n, o_strobe && !o_result.last, busy, "word without last while sequencer idle")
    `ITAF_ASSERT_NOW(a_count_step, i_clk, i_rst_n, o_strobe && $past(o_strobe), o_result.total_chars == $past(o_result.total_chars) + 32'd1, "running count did not advance by one")
    `ITAF_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy && (i_item.opcode <= OP_PTR), busy, "valid opcode accepted but sequencer stayed idle")
    `ITAF_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_strobe && o_result.last, !o_strobe, "word emitted right after last")

endmodule
